[hdl/bphc_pkg.sv]
// Shared types and constants for the button press and hold classifier.
package bphc_pkg;

	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 16;

	// Register indexes of the configuration port
	localparam logic [CfgIdxW-1:0] REG_ACTIVE_LEVEL     = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_SHORT_HOLD_MS    = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_MEDIUM_HOLD_MS   = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_LONG_HOLD_MS     = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_SHORT_REPEAT_MS  = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_MEDIUM_REPEAT_MS = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_LONG_REPEAT_MS   = 3'd6;

	// Event codes
	localparam logic [2:0] EV_NONE    = 3'd0;
	localparam logic [2:0] EV_PRESS   = 3'd1;
	localparam logic [2:0] EV_RELEASE = 3'd2;
	localparam logic [2:0] EV_SHORT   = 3'd3;
	localparam logic [2:0] EV_MEDIUM  = 3'd4;
	localparam logic [2:0] EV_LONG    = 3'd5;

	// Operations
	localparam logic OP_POLL    = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	typedef struct packed {
		logic        op;
		logic        pin_level;
		logic [31:0] now_ms;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  event_res;
		logic        pressed;
		logic [31:0] held_ms;
	} out_word_t;

	typedef struct packed {
		logic        active_level;
		logic [15:0] short_hold_ms;
		logic [15:0] medium_hold_ms;
		logic [15:0] long_hold_ms;
		logic [15:0] short_repeat_ms;
		logic [15:0] medium_repeat_ms;
		logic [15:0] long_repeat_ms;
	} cfg_t;

endpackage

[hdl/bphc_cfg_regs.sv]
// Configuration register file of the button press and hold classifier.
module bphc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bphc_pkg::CfgIdxW-1:0]   cfg_idx,
	input  logic [bphc_pkg::CfgDataW-1:0]  cfg_wdata,
	output bphc_pkg::cfg_t                 cfg
);

	bphc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_level     <= 1'b0;
			cfg_q.short_hold_ms    <= 16'd500;
			cfg_q.medium_hold_ms   <= 16'd1500;
			cfg_q.long_hold_ms     <= 16'd3000;
			cfg_q.short_repeat_ms  <= 16'd500;
			cfg_q.medium_repeat_ms <= 16'd250;
			cfg_q.long_repeat_ms   <= 16'd100;
		end else if (cfg_we) begin
			case (cfg_idx)
				bphc_pkg::REG_ACTIVE_LEVEL:     cfg_q.active_level     <= cfg_wdata[0];
				bphc_pkg::REG_SHORT_HOLD_MS:    cfg_q.short_hold_ms    <= cfg_wdata;
				bphc_pkg::REG_MEDIUM_HOLD_MS:   cfg_q.medium_hold_ms   <= cfg_wdata;
				bphc_pkg::REG_LONG_HOLD_MS:     cfg_q.long_hold_ms     <= cfg_wdata;
				bphc_pkg::REG_SHORT_REPEAT_MS:  cfg_q.short_repeat_ms  <= cfg_wdata;
				bphc_pkg::REG_MEDIUM_REPEAT_MS: cfg_q.medium_repeat_ms <= cfg_wdata;
				bphc_pkg::REG_LONG_REPEAT_MS:   cfg_q.long_repeat_ms   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hdl/bphc_step.sv]
// Button state registers and the per-word classification logic.
module bphc_step (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  bphc_pkg::in_word_t  item,
	input  bphc_pkg::cfg_t      cfg,
	output bphc_pkg::out_word_t result
);

	logic        last_level_q;
	logic [31:0] press_start_q;
	logic [31:0] last_report_q;
	logic        timing_on_q;

	logic        level_nx;
	logic [31:0] press_start_nx;
	logic [31:0] last_report_nx;
	logic        timing_on_nx;
	logic [2:0]  ev;
	logic        down_nx;
	logic [31:0] hold;
	logic [31:0] gap;
	logic        ge_short, ge_medium, ge_long;

	assign hold      = item.now_ms - press_start_q;
	// Before the first timed report the gap counts from this very poll.
	assign gap       = timing_on_q ? (item.now_ms - last_report_q) : 32'd0;
	assign ge_short  = hold >= {16'd0, cfg.short_hold_ms};
	assign ge_medium = hold >= {16'd0, cfg.medium_hold_ms};
	assign ge_long   = hold >= {16'd0, cfg.long_hold_ms};

	always_comb begin
		level_nx       = last_level_q;
		press_start_nx = press_start_q;
		last_report_nx = last_report_q;
		timing_on_nx   = timing_on_q;
		ev             = bphc_pkg::EV_NONE;
		if (item.op == bphc_pkg::OP_RESTART) begin
			if (last_level_q == cfg.active_level) begin
				press_start_nx = item.now_ms;
			end
		end else if (item.pin_level != last_level_q) begin
			if (item.pin_level == cfg.active_level) begin
				ev             = bphc_pkg::EV_PRESS;
				press_start_nx = item.now_ms;
			end else begin
				ev             = bphc_pkg::EV_RELEASE;
				press_start_nx = 32'd0;
			end
			timing_on_nx = 1'b0;
			level_nx     = item.pin_level;
		end else if (last_level_q == cfg.active_level) begin
			timing_on_nx = 1'b1;
			if (ge_long && gap >= {16'd0, cfg.long_repeat_ms}) begin
				ev = bphc_pkg::EV_LONG;
			end else if (ge_medium && !ge_long && gap >= {16'd0, cfg.medium_repeat_ms}) begin
				ev = bphc_pkg::EV_MEDIUM;
			end else if (ge_short && !ge_medium && gap >= {16'd0, cfg.short_repeat_ms}) begin
				ev = bphc_pkg::EV_SHORT;
			end
			if (ev != bphc_pkg::EV_NONE || !timing_on_q) begin
				last_report_nx = item.now_ms;
			end
		end
	end

	assign down_nx          = level_nx == cfg.active_level;
	assign result.event_res = ev;
	assign result.pressed   = down_nx;
	assign result.held_ms   = down_nx ? (item.now_ms - press_start_nx) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q  <= 1'b1;
			press_start_q <= 32'd0;
			last_report_q <= 32'd0;
			timing_on_q   <= 1'b0;
		end else if (advance) begin
			last_level_q  <= level_nx;
			press_start_q <= press_start_nx;
			last_report_q <= last_report_nx;
			timing_on_q   <= timing_on_nx;
		end
	end

endmodule

[hdl/button_press_hold_classifier.sv]
// Top level of the button press and hold classifier.
//
// Input channel: in_valid / in_stall / in_word carry one poll or restart word
// (op, pin_level, now_ms). Output channel: out_valid / out_stall / out_word
// return exactly one result word (event_res, pressed, held_ms) per input word,
// in order.
// Flow: a word accepted into the input register is classified as it leaves;
// its result is written into the result register and shown on out_valid.
// Throughput: one word per cycle unless stalled. The input register and the
// result register form a two-deep pipeline; the button state is updated as
// each word leaves the input register, so consecutive words see each other's
// effects.
// When out_stall holds a pending result, the result register holds still, the
// input register fills, and in_stall rises once both are occupied.
// Configuration: cfg_we, cfg_idx and cfg_wdata write one register per edge;
// writes are meant for idle periods only. Unused indexes are ignored.
// Reset (arst_n low) empties both registers, restores the default thresholds
// and repeat gaps, and leaves the button released with no timing under way.
module button_press_hold_classifier (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  bphc_pkg::in_word_t             in_word,
	output logic                           out_valid,
	input  logic                           out_stall,
	output bphc_pkg::out_word_t            out_word,
	input  logic                           cfg_we,
	input  logic [bphc_pkg::CfgIdxW-1:0]   cfg_idx,
	input  logic [bphc_pkg::CfgDataW-1:0]  cfg_wdata
);

	bphc_pkg::cfg_t      cfg;
	bphc_pkg::in_word_t  item_s1;
	logic                valid_s1;
	bphc_pkg::out_word_t result;
	bphc_pkg::out_word_t out_word_q;
	logic                out_valid_q;
	logic                move;

	// The pipeline moves whenever the result register is free or being taken.
	assign move     = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !move;

	bphc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	bphc_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (valid_s1 && move),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move && valid_s1) begin
			out_word_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// Released words never report a held time.
	a_released_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.pressed |-> out_word.held_ms == 32'd0)
		else $error("held_ms non-zero while released");

	// A press starts the hold timer at zero.
	a_press_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.event_res == bphc_pkg::EV_PRESS
		|-> out_word.pressed && out_word.held_ms == 32'd0)
		else $error("press result without zero hold");

	// Short, medium and long hold events come only with the pressed flag set.
	a_event_vs_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_word.event_res == bphc_pkg::EV_SHORT ||
		out_word.event_res == bphc_pkg::EV_MEDIUM ||
		out_word.event_res == bphc_pkg::EV_LONG) |-> out_word.pressed)
		else $error("hold event while released");

	// Input is only held back when both pipeline registers are occupied.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled with room in the pipeline");

endmodule
